[src/sla_pkg.sv]
// Shared types, constants and the access decoder of the store/load alias detector.
// No dependencies; every other file of the block imports this package.
package sla_pkg;

	localparam int WORD_W          = 32;
	localparam int KEY_W           = 41;
	localparam int HELD_W          = 6;
	localparam int MAX_STORES_DEF  = 32;
	localparam int QDEPTH          = 2;
	localparam int KEY_UNSCALED    = 40;

	localparam logic [WORD_W-1:0] UIMM_MASK  = 32'h3B00_0000;
	localparam logic [WORD_W-1:0] UIMM_MATCH = 32'h3900_0000;
	localparam logic [WORD_W-1:0] UNSC_MASK  = 32'h3B20_0C00;
	localparam logic [WORD_W-1:0] UNSC_MATCH = 32'h3800_0000;
	localparam logic [1:0]        OPC_STORE  = 2'b00;

	typedef struct packed {
		logic             first;
		logic             last;
		logic             is_store;
		logic             is_load;
		logic [KEY_W-1:0] key;
	} access_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SRCH
	} back_state_t;

	// Classify one word; first/last are filled in by the caller.
	function automatic access_t decode_access(input logic [WORD_W-1:0] w);
		access_t a;
		a = '0;
		a.key[25:24] = w[31:30];
		a.key[16:12] = w[9:5];
		if ((w & UIMM_MASK) == UIMM_MATCH) begin
			a.key[11:0] = w[21:10];
			a.is_store  = (w[23:22] == OPC_STORE);
			a.is_load   = (w[23:22] != OPC_STORE);
		end else if ((w & UNSC_MASK) == UNSC_MATCH) begin
			a.key[KEY_UNSCALED] = 1'b1;
			a.key[8:0]          = w[20:12];
			a.is_store          = (w[23:22] == OPC_STORE);
			a.is_load           = (w[23:22] != OPC_STORE);
		end
		return a;
	endfunction

endpackage

[src/sla_if.sv]
// Valid/ready channel interfaces: instruction words in, scan results out.
// Depends on sla_pkg for field widths.
interface sla_in_if import sla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] instruction_word;
	logic              first_of_body;
	logic              last_of_body;

	modport source(output valid, instruction_word, first_of_body, last_of_body, input ready);
	modport sink(input valid, instruction_word, first_of_body, last_of_body, output ready);
endinterface

interface sla_out_if import sla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hazard_found;
	logic              scan_done;
	logic [HELD_W-1:0] stores_held;

	modport source(output valid, hazard_found, scan_done, stores_held, input ready);
	modport sink(input valid, hazard_found, scan_done, stores_held, output ready);
endinterface

[src/sla_front.sv]
// Front end: accepts instruction words, decodes them into access records, queues them.
// Depends on sla_pkg and sla_if.
module sla_front import sla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sla_in_if.sink    insn,
	output access_t   acc,
	output logic      acc_valid,
	input  logic      acc_ready
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

	access_t          entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	access_t          dec;
	logic             push, pop;

	always_comb begin
		dec       = decode_access(insn.instruction_word);
		dec.first = insn.first_of_body;
		dec.last  = insn.last_of_body;
	end

	assign insn.ready = (cnt_q != FULL_CNT);
	assign push       = insn.valid && insn.ready;
	assign acc_valid  = (cnt_q != '0);
	assign pop        = acc_valid && acc_ready;
	assign acc        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/sla_back.sv]
// Back end: store key table, sequential load search, sticky hazard flag, result register.
// Depends on sla_pkg and sla_if.
module sla_back import sla_pkg::*; #(
	parameter int MAX_STORES = MAX_STORES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  access_t   acc,
	input  logic      acc_valid,
	output logic      acc_ready,
	sla_out_if.source result
);

	localparam int CNT_W = $clog2(MAX_STORES + 1);
	localparam int IDX_W = (MAX_STORES > 1) ? $clog2(MAX_STORES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STORES);

	logic [KEY_W-1:0] mem [MAX_STORES];
	logic [KEY_W-1:0] rd_data_q;

	back_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, cnt_base;
	logic             hazard_q, hazard_d, haz_base;
	logic [KEY_W-1:0] key_q, key_d;
	logic             last_q, last_d;
	logic             pop, mem_we, mem_re, out_load, out_last, out_free, hit;
	logic [IDX_W-1:0] rd_addr;

	logic              out_valid_q;
	logic              hazard_found_q, scan_done_q;
	logic [HELD_W-1:0] stores_held_q;

	assign out_free  = !out_valid_q || result.ready;
	assign acc_ready = pop;
	assign hit       = (rd_data_q == key_q);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		hazard_d = hazard_q;
		idx_d    = idx_q;
		key_d    = key_q;
		last_d   = last_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rd_addr  = '0;
		out_load = 1'b0;
		out_last = last_q;
		cnt_base = acc.first ? '0 : count_q;
		haz_base = acc.first ? 1'b0 : hazard_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_valid && out_free) begin
					pop      = 1'b1;
					count_d  = cnt_base;
					hazard_d = haz_base;
					out_last = acc.last;
					key_d    = acc.key;
					last_d   = acc.last;
					if (acc.is_store) begin
						out_load = 1'b1;
						if (cnt_base < MAX_CNT) begin
							mem_we  = 1'b1;
							count_d = cnt_base + CNT_W'(1);
						end
					end else if (acc.is_load && cnt_base != '0 && !haz_base) begin
						mem_re  = 1'b1;
						idx_d   = CNT_W'(1);
						state_d = ST_SRCH;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ST_SRCH: begin
				if (hit || idx_q == count_q) begin
					hazard_d = hazard_q | hit;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					mem_re  = 1'b1;
					rd_addr = idx_q[IDX_W-1:0];
					idx_d   = idx_q + CNT_W'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_base[IDX_W-1:0]] <= acc.key;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		last_q <= last_d;
		idx_q  <= idx_d;
		if (out_load) begin
			hazard_found_q <= hazard_d;
			scan_done_q    <= out_last;
			stores_held_q  <= HELD_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hazard_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			hazard_q <= hazard_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.hazard_found = hazard_found_q;
	assign result.scan_done    = scan_done_q;
	assign result.stores_held  = stores_held_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("store count above table depth");

	a_srch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> (idx_q != '0 && idx_q <= count_q))
		else $error("search index outside held entries");

	a_srch_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> !out_valid_q)
		else $error("result pending during table search");

	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && out_free))
		else $error("record taken while back end busy");

endmodule

[src/store_load_alias_detector.sv]
// Top level of the store/load alias detector: front decoder/queue and back table search.
// Depends on sla_pkg, sla_if, sla_front and sla_back.
//
//  channel  dir  transaction      fields
//  insn     in   one word         instruction_word[31:0], first_of_body, last_of_body
//  result   out  one per word     hazard_found, scan_done, stores_held[5:0]
//
// Stores, loads that need no lookup and other words go straight to the result register.
// A load with N held keys and a clear flag is searched one table entry per cycle
// through the single read port; the scan stops at the first match.
// Reset clears queue, store count, hazard flag and result valid; table contents stay.
// A two-entry queue lets the front take words while the back end scans or the
// result register waits; the back end takes a record only when the result can move.
module store_load_alias_detector import sla_pkg::*; #(
	parameter int MAX_STORES = MAX_STORES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sla_in_if.sink    insn,
	sla_out_if.source result
);

	access_t acc;
	logic    acc_valid, acc_ready;

	sla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.insn      (insn),
		.acc       (acc),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready)
	);

	sla_back #(
		.MAX_STORES (MAX_STORES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.result    (result)
	);

endmodule

[dv/sla_scoreboard.sv]
// Scoreboard for the store/load alias detector: watches both channels, predicts each scan result.
// Depends on sla_pkg and the sla_in_if / sla_out_if interfaces.
module sla_scoreboard import sla_pkg::*; #(
	parameter int DEPTH = MAX_STORES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sla_in_if    insn,
	sla_out_if   result,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		logic              hazard;
		logic              done;
		logic [HELD_W-1:0] held;
	} scan_t;

	logic [KEY_W-1:0] held_keys [DEPTH];
	int               held_count = 0;
	logic             hazard = 1'b0;
	scan_t            expected_scans [$];
	int               mismatches = 0;
	int               outstanding = 0;

	logic [KEY_W-1:0] key;
	logic [1:0]       op;
	scan_t            want;
	scan_t            got;

	assign fails   = mismatches;
	assign pending = outstanding;

	function automatic bit access_key(input logic [WORD_W-1:0] w, output logic [KEY_W-1:0] k,
			output logic [1:0] opc);
		k   = '0;
		opc = w[23:22];
		if (w[29:27] == 3'b111 && w[25:24] == 2'b01) begin
			k = {1'b0, 14'd0, w[31:30], 7'd0, w[9:5], w[21:10]};
			return 1'b1;
		end
		if (w[29:27] == 3'b111 && w[25:24] == 2'b00 && !w[21] && w[11:10] == 2'b00) begin
			k = {1'b1, 14'd0, w[31:30], 7'd0, w[9:5], 3'd0, w[20:12]};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic mismatch(input string what, input longint exp_v, input longint act_v);
		if (mismatches < 10)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			hazard = 1'b0;
			expected_scans.delete();
			outstanding = 0;
		end else begin
			if (insn.valid && insn.ready) begin
				if (insn.first_of_body) begin
					held_count = 0;
					hazard = 1'b0;
				end
				if (access_key(insn.instruction_word, key, op)) begin
					if (op == OPC_STORE) begin
						if (held_count < DEPTH) begin
							held_keys[held_count] = key;
							held_count++;
						end
					end else begin
						for (int i = 0; i < held_count; i++)
							if (held_keys[i] == key)
								hazard = 1'b1;
					end
				end
				want.hazard = hazard;
				want.done   = insn.last_of_body;
				want.held   = HELD_W'(held_count);
				expected_scans.push_back(want);
			end
			if (result.valid && result.ready) begin
				got.hazard = result.hazard_found;
				got.done   = result.scan_done;
				got.held   = result.stores_held;
				if (expected_scans.size() == 0) begin
					mismatch("results pending", 1, 0);
				end else begin
					want = expected_scans.pop_front();
					if (got.hazard !== want.hazard)
						mismatch("hazard_found", want.hazard, got.hazard);
					if (got.done !== want.done)
						mismatch("scan_done", want.done, got.done);
					if (got.held !== want.held)
						mismatch("stores_held", want.held, got.held);
				end
			end
			outstanding = expected_scans.size();
		end
	end

endmodule

[dv/testbench.sv]
// Top of the alias detector testbench: clock, reset, word stimulus, result back-pressure, verdict.
// Depends on sla_pkg, the sla interfaces, store_load_alias_detector and sla_scoreboard.
module testbench;
	import sla_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   steady = 1'b0;
	int   accesses = 0;
	int   next_drain;

	logic [1:0] pool_size;
	logic [4:0] pool_base [2];

	sla_in_if  insn();
	sla_out_if result();

	store_load_alias_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.insn   (insn),
		.result (result)
	);

	sla_scoreboard scb (
		.clk     (clk),
		.arst_n  (arst_n),
		.insn    (insn),
		.result  (result),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] scaled_word(logic [1:0] sz, logic [1:0] op, logic [4:0] rn,
			logic [11:0] off);
		return {sz, 3'b111, 1'($urandom), 2'b01, op, off, rn, 5'($urandom)};
	endfunction

	function automatic logic [31:0] unscaled_word(logic [1:0] sz, logic [1:0] op, logic [4:0] rn,
			logic [8:0] off);
		return {sz, 3'b111, 1'($urandom), 2'b00, op, 1'b0, off, 2'b00, rn, 5'($urandom)};
	endfunction

	// small key space so loads hit earlier stores often
	function automatic logic [31:0] pool_word(bit st);
		logic [1:0] op;
		logic [1:0] sz;
		logic [4:0] rn;
		op = st ? OPC_STORE : 2'($urandom_range(1, 3));
		sz = ($urandom_range(0, 3) == 0) ? 2'($urandom) : pool_size;
		rn = $urandom_range(0, 1) ? pool_base[0] : pool_base[1];
		if ($urandom_range(0, 1))
			return scaled_word(sz, op, rn, 12'($urandom_range(0, 3)));
		return unscaled_word(sz, op, rn, 9'($urandom_range(0, 3)));
	endfunction

	function automatic logic [31:0] any_access();
		if ($urandom_range(0, 1))
			return scaled_word(2'($urandom), 2'($urandom), 5'($urandom), 12'($urandom));
		return unscaled_word(2'($urandom), 2'($urandom), 5'($urandom), 9'($urandom));
	endfunction

	task automatic send_word(input logic [31:0] w, input logic f, input logic l);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			insn.valid <= 1'b0;
			@(posedge clk);
		end
		insn.valid            <= 1'b1;
		insn.instruction_word <= w;
		insn.first_of_body    <= f;
		insn.last_of_body     <= l;
		@(posedge clk);
		while (!insn.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		insn.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// 36 distinct stores: the last four are dropped once the table is full
	task automatic fill_table();
		for (int i = 0; i < 36; i++) begin
			send_word(scaled_word(2'd3, OPC_STORE, 5'd7, 12'(i)), i == 0, 1'b0);
			accesses++;
		end
		send_word(scaled_word(2'd3, 2'd1, 5'd7, 12'd34), 1'b0, 1'b0);
		send_word(scaled_word(2'd3, 2'd2, 5'd7, 12'd31), 1'b0, 1'b1);
		accesses += 2;
	endtask

	task automatic run_body();
		int   len;
		int   kind;
		int   store_pct;
		logic [31:0] w;
		bit   mark_first;
		bit   mark_last;
		pool_size    = 2'($urandom);
		pool_base[0] = 5'($urandom);
		pool_base[1] = 5'($urandom);
		if ($urandom_range(0, 9) < 2) begin
			len = $urandom_range(20, 45);
			store_pct = 65;
		end else begin
			len = $urandom_range(1, 12);
			store_pct = 35;
		end
		mark_first = ($urandom_range(0, 9) != 0);
		mark_last  = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 5) == 0)
			steady = !steady;
		for (int i = 0; i < len; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < store_pct) begin
				w = pool_word(1'b1);
				accesses++;
			end else if (kind < 80) begin
				w = pool_word(1'b0);
				accesses++;
			end else if (kind < 90) begin
				w = any_access();
				accesses++;
			end else begin
				w = $urandom;
			end
			send_word(w, (i == 0) ? mark_first : ($urandom_range(0, 49) == 0),
				(i == len - 1) ? mark_last : ($urandom_range(0, 49) == 0));
		end
	endtask

	// result side back-pressure
	initial begin
		int stall;
		result.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				result.ready <= 1'b0;
				@(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid)
				@(posedge clk);
		end
	end

	initial begin
		arst_n                = 1'b0;
		insn.valid            = 1'b0;
		insn.instruction_word = '0;
		insn.first_of_body    = 1'b0;
		insn.last_of_body     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first mark after reset; extreme fields; hazard stays set while stores go on
		send_word(scaled_word(2'd3, OPC_STORE, 5'd31, 12'hFFF), 1'b0, 1'b0);
		send_word(scaled_word(2'd3, 2'd1, 5'd31, 12'hFFF), 1'b0, 1'b0);
		send_word(unscaled_word(2'd0, OPC_STORE, 5'd0, 9'h1FF), 1'b0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
		// new body: form, size and base all part of the key
		send_word(32'h0000_0000, 1'b1, 1'b0);
		send_word(scaled_word(2'd1, OPC_STORE, 5'd3, 12'd5), 1'b0, 1'b0);
		send_word(unscaled_word(2'd1, 2'd1, 5'd3, 9'd5), 1'b0, 1'b0);
		send_word(scaled_word(2'd2, 2'd2, 5'd3, 12'd5), 1'b0, 1'b0);
		send_word(scaled_word(2'd1, 2'd3, 5'd4, 12'd5), 1'b0, 1'b0);
		send_word(scaled_word(2'd1, 2'd3, 5'd3, 12'd5), 1'b0, 1'b1);
		// words after a last mark without a new first mark
		send_word(unscaled_word(2'd0, 2'd2, 5'd0, 9'h1FF), 1'b0, 1'b0);
		send_word(unscaled_word(2'd3, OPC_STORE, 5'd31, 9'h1FF), 1'b1, 1'b0);
		send_word(unscaled_word(2'd3, 2'd2, 5'd31, 9'h1FF) | 32'h0020_0000, 1'b0, 1'b0);
		send_word(unscaled_word(2'd3, 2'd3, 5'd31, 9'h1FF) | 32'h0000_0400, 1'b0, 1'b0);
		send_word(unscaled_word(2'd3, 2'd2, 5'd31, 9'h1FF), 1'b0, 1'b0);
		send_word(scaled_word(2'd3, 2'd1, 5'd31, 12'h1FF), 1'b1, 1'b1);
		send_word(scaled_word(2'd0, OPC_STORE, 5'd0, 12'd0), 1'b1, 1'b0);
		send_word(scaled_word(2'd0, 2'd1, 5'd0, 12'd0), 1'b0, 1'b0);
		send_word(scaled_word(2'd0, OPC_STORE, 5'd1, 12'd0), 1'b0, 1'b1);
		accesses += 15;
		drain();

		fill_table();
		drain();

		next_drain = 300;
		while (accesses < 1200) begin
			run_body();
			if (accesses >= next_drain) begin
				drain();
				next_drain += 300;
			end
		end

		insn.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
